@@ sv/v2p_pkg.sv @@
// ----------------------------------------------------------------------------
// v2p_pkg
// Shared types, constants and helpers of the v210 to P010 converter.
// ----------------------------------------------------------------------------
package v2p_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int OUT_SMP_W   = 16;
    localparam int ROW_W       = 12;
    localparam int POS_W       = 10;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 128;
    localparam int RES_W       = ROW_W + POS_W + 6 * OUT_SMP_W + CNT_W;
    localparam int LINE_W      = 6 * SAMPLE_W;

    // floor(x / 6) == (x * RECIP_6) >> 16 for every 14-bit x
    localparam logic [13:0] RECIP_6 = 14'd10923;

    localparam logic [CFG_DATA_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [CNT_W-1:0]      FULL_CNT   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    typedef logic [5:0][SAMPLE_W-1:0] t_six;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] luma_cnt;
        logic [CNT_W-1:0] chroma_cnt;
        logic             odd_row;
        logic             two;
    } t_s1_ctrl;

    function automatic t_six luma_of(input logic [IN_TDATA_W-1:0] d);
        t_six y;
        y[0] = d[19:10];
        y[1] = d[41:32];
        y[2] = d[61:52];
        y[3] = d[83:74];
        y[4] = d[105:96];
        y[5] = d[125:116];
        return y;
    endfunction

    function automatic t_six chroma_of(input logic [IN_TDATA_W-1:0] d);
        t_six c;
        c[0] = d[9:0];
        c[1] = d[29:20];
        c[2] = d[51:42];
        c[3] = d[73:64];
        c[4] = d[93:84];
        c[5] = d[115:106];
        return c;
    endfunction

    // Layout from bit 0: row, pos, sample_0 .. sample_5, count.
    function automatic logic [RES_W-1:0] pack_result(
        input logic [ROW_W-1:0] row,
        input logic [POS_W-1:0] pos,
        input t_six             smp,
        input logic [CNT_W-1:0] cnt
    );
        logic [6*OUT_SMP_W-1:0] s;
        for (int i = 0; i < 6; i++) begin
            s[i*OUT_SMP_W +: OUT_SMP_W] = {smp[i], 6'd0};
        end
        return {cnt, s, pos, row};
    endfunction

endpackage

@@ sv/v2p_line_buf.sv @@
// ----------------------------------------------------------------------------
// v2p_line_buf
// Chroma line buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module v2p_line_buf #(
    parameter int DEPTH = 683,
    parameter int AW    = 10,
    parameter int DW    = 60
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/v210_to_p010_converter_unit.sv @@
// ----------------------------------------------------------------------------
// v210_to_p010_converter_unit
// Converts v210 groups (six pixels, four words) into P010 luma and chroma.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one v210 group per transaction, raster order,
// ceil(frame_width/6) groups per row. Output stream (m_axis): a luma result
// for every group; on odd rows (and on the last row of an odd-height frame)
// a chroma result follows it. tuser marks the plane, tlast the final result
// of a group. Configuration port: write frame_width (index 0) or
// frame_height (index 1) while the block is idle; it is always ready.
// Path: an input group is registered in stage 1, then in the output
// register that drives m_axis. Throughput: one output transaction per
// cycle while m_axis_tready is high, so one group per cycle on rows that
// emit luma only and a group per two transactions on rows that emit luma
// and chroma, as the single output register holds both results of a group.
// Reset clears the counters and the pipeline and sets 1920 x 1080 (width capped at MAX_WIDTH). The line
// buffer is not cleared; even rows fill it before odd rows read it.
// When m_axis stalls, the output register holds and s_axis keeps accepting
// until the one-group input stage is also full.
// ----------------------------------------------------------------------------
module v210_to_p010_converter_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [v2p_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [v2p_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input groups
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // word_a [31:0], word_b [63:32], word_c [95:64], word_d [127:96]
    input  logic [v2p_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_row [11:0], group_pos [21:12], sample_0..sample_5 [117:22]
    // (16 bits each), valid_count [120:118], zeros [127:121]
    output logic [v2p_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // plane [0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 5) / 6;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW         = $clog2(LINE_DEPTH + 1);
    localparam int RST_W      = (MAX_WIDTH < 1920) ? MAX_WIDTH : 1920;
    localparam int RST_GROUPS = (RST_W + 5) / 6;
    localparam int RST_REM    = RST_W % 6;
    localparam int RES_W      = v2p_pkg::RES_W;

    // ---------------- configuration ----------------
    logic [CW-1:0]                    r_groups;
    logic [2:0]                       r_rem;
    logic [v2p_pkg::CFG_DATA_W-1:0]   r_height;

    logic [13:0] cfg_w;
    logic [27:0] cfg_prod;
    logic [13:0] cfg_q;
    logic [13:0] cfg_r;
    logic [CW-1:0] n_groups;
    logic [v2p_pkg::CFG_DATA_W-1:0] n_height;

    always_comb begin
        cfg_w = {1'b0, i_cfg_data};
        if (cfg_w == 14'd0) begin
            cfg_w = 14'd1;
        end else if (cfg_w > 14'(MAX_WIDTH)) begin
            cfg_w = 14'(MAX_WIDTH);
        end
        cfg_prod = cfg_w * v2p_pkg::RECIP_6;
        cfg_q    = 14'(cfg_prod >> 16);
        cfg_r    = cfg_w - 14'(cfg_q * 14'd6);
        n_groups = CW'(cfg_q) + CW'(cfg_r != 14'd0);

        n_height = i_cfg_data;
        if (n_height == '0) begin
            n_height = 13'd1;
        end else if (n_height > v2p_pkg::MAX_HEIGHT) begin
            n_height = v2p_pkg::MAX_HEIGHT;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups <= CW'(RST_GROUPS);
            r_rem    <= 3'(RST_REM);
            r_height <= 13'd1080;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == v2p_pkg::REG_FRAME_WIDTH) begin
                r_groups <= n_groups;
                r_rem    <= cfg_r[2:0];
            end else if (i_cfg_index == v2p_pkg::REG_FRAME_HEIGHT) begin
                r_height <= n_height;
            end
        end
    end

    // ---------------- input side: position tracking ----------------
    logic [AW-1:0]              r_group;
    logic [v2p_pkg::ROW_W-1:0]  r_row;
    logic [AW-1:0]              n_group;
    logic [v2p_pkg::ROW_W-1:0]  n_row;
    logic [AW-1:0]              cur_group;
    logic [v2p_pkg::ROW_W-1:0]  cur_row;
    logic                       last_group;
    logic                       last_row;
    logic                       store;
    logic                       in_take;
    v2p_pkg::t_s1_ctrl          n_ctrl;

    assign in_take = s_axis_tvalid & s_axis_tready;

    always_comb begin
        cur_group  = (CW'(r_group) >= r_groups) ? '0 : r_group;
        cur_row    = ({1'b0, r_row} >= r_height) ? '0 : r_row;
        last_group = (CW'(cur_group) + CW'(1)) == r_groups;
        last_row   = ({1'b0, cur_row} + 13'd1) == r_height;
        store      = ~cur_row[0] & ~last_row;

        n_ctrl.row        = cur_row;
        n_ctrl.pos        = v2p_pkg::POS_W'(cur_group);
        n_ctrl.luma_cnt   = (last_group && r_rem != 3'd0) ? r_rem : v2p_pkg::FULL_CNT;
        n_ctrl.chroma_cnt = (n_ctrl.luma_cnt + 3'd1) & 3'b110;
        n_ctrl.odd_row    = cur_row[0];
        n_ctrl.two        = ~store;

        if (last_group) begin
            n_group = '0;
            n_row   = last_row ? '0 : cur_row + 12'd1;
        end else begin
            n_group = cur_group + AW'(1);
            n_row   = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_row   <= '0;
        end else if (in_take) begin
            r_group <= n_group;
            r_row   <= n_row;
        end
    end

    // ---------------- line buffer ----------------
    logic [v2p_pkg::LINE_W-1:0] line_rdata;

    v2p_line_buf #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW),
        .DW    (v2p_pkg::LINE_W)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (in_take & store),
        .i_waddr (cur_group),
        .i_wdata (v2p_pkg::chroma_of(s_axis_tdata)),
        .i_re    (in_take),
        .i_raddr (cur_group),
        .o_rdata (line_rdata)
    );

    // ---------------- stage 1 ----------------
    logic              r_s1_valid;
    v2p_pkg::t_s1_ctrl r_s1_ctrl;
    v2p_pkg::t_six     r_s1_y;
    v2p_pkg::t_six     r_s1_c;

    // ---------------- output register ----------------
    logic             r_out_valid;
    logic             r_out_phase;
    logic             r_out_two;
    logic [RES_W-1:0] r_out_luma;
    logic [RES_W-1:0] r_out_chroma;
    logic             out_take;
    logic             out_last;
    logic             out_free;

    assign out_take      = r_out_valid & m_axis_tready;
    assign out_last      = r_out_phase | ~r_out_two;
    assign out_free      = ~r_out_valid | (out_take & out_last);
    assign s_axis_tready = ~r_s1_valid | out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_ctrl <= n_ctrl;
            r_s1_y    <= v2p_pkg::luma_of(s_axis_tdata);
            r_s1_c    <= v2p_pkg::chroma_of(s_axis_tdata);
        end
    end

    v2p_pkg::t_six    avg;
    logic [RES_W-1:0] n_out_luma;
    logic [RES_W-1:0] n_out_chroma;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            if (r_s1_ctrl.odd_row) begin
                avg[i] = 10'(({1'b0, line_rdata[i*10 +: 10]} + {1'b0, r_s1_c[i]}) >> 1);
            end else begin
                avg[i] = r_s1_c[i];
            end
        end
        n_out_luma   = v2p_pkg::pack_result(r_s1_ctrl.row, r_s1_ctrl.pos, r_s1_y,
                                            r_s1_ctrl.luma_cnt);
        n_out_chroma = v2p_pkg::pack_result({1'b0, r_s1_ctrl.row[11:1]}, r_s1_ctrl.pos,
                                            avg, r_s1_ctrl.chroma_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_phase <= 1'b0;
            r_out_two   <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
            r_out_phase <= 1'b0;
            r_out_two   <= r_s1_ctrl.two;
        end else if (out_take) begin
            r_out_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_luma   <= n_out_luma;
            r_out_chroma <= n_out_chroma;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = v2p_pkg::OUT_TDATA_W'(r_out_phase ? r_out_chroma : r_out_luma);
    assign m_axis_tuser  = r_out_phase;
    assign m_axis_tlast  = out_last;

    // ---------------- assertions ----------------
    a_chroma_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("chroma result not marked last");

    a_chroma_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser)
        else $error("luma result without following chroma result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[120:118] != 3'd0 && m_axis_tdata[120:118] <= 3'd6)
        else $error("valid count out of range");

    a_group_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_take) && !$past(i_cfg_valid) |-> CW'(r_group) < r_groups)
        else $error("group counter beyond row");

endmodule
